### src/twled_pkg.sv
// Shared types and command constants for the two-wire LED driver writer.
package twled_pkg;

    // Input operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_BRIGHT_EN  = 2'd1;
    localparam logic [1:0] REG_HALF_BIT   = 2'd2;

    // Driver command bytes
    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY    = 8'h80;

    localparam logic [3:0]  BRIGHTNESS_RST = 4'd8;
    localparam logic [15:0] HALF_BIT_RST   = 16'd100;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LOAD,
        CMD_START,
        CMD_NOP
    } t_cmd_kind;

    // Classified item handed from the front to the sequencer
    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  digit_index;
        logic [7:0]  segment_byte;
        logic [2:0]  update_length;
        logic [1:0]  start_position;
    } t_cmd_item;

endpackage

### src/twled_front.sv
// Front end: decodes input items and holds them in a two-entry queue.
module twled_front
    import twled_pkg::*;
#(
    parameter int DIGIT_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_digit_index,
    input  logic [7:0]  i_segment_byte,
    input  logic [2:0]  i_update_length,
    input  logic [1:0]  i_start_position,
    output logic        o_q_valid,
    output t_cmd_item   o_q_item,
    input  logic        i_q_pop
);

    localparam logic [2:0] MAX_DIGITS = 3'(DIGIT_COUNT);

    t_cmd_item  in_item;
    t_cmd_item  r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    always_comb begin
        in_item.digit_index    = i_digit_index;
        in_item.segment_byte   = i_segment_byte;
        in_item.start_position = i_start_position;
        in_item.update_length  = (i_update_length > MAX_DIGITS) ? MAX_DIGITS : i_update_length;
        unique case (i_operation)
            OP_TICK:  in_item.kind = CMD_TICK;
            OP_LOAD:  in_item.kind = (i_digit_index < MAX_DIGITS) ? CMD_LOAD : CMD_NOP;
            OP_START: in_item.kind = CMD_START;
            default:  in_item.kind = CMD_NOP;
        endcase
    end

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_item;
        end
    end

`ifndef SYNTHESIS
    // Pointers differ exactly when the queue holds one item
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

### src/twled_back.sv
// Back end: digit store, registers and the pin sequencer with its result register.
module twled_back
    import twled_pkg::*;
#(
    parameter int DIGIT_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_valid,
    input  t_cmd_item   i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_clock_pin,
    output logic        o_data_pin,
    output logic        o_busy
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_BIT_LOW,
        PH_BIT_DATA,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_LOW,
        PH_STOP_DLOW,
        PH_STOP_HIGH,
        PH_STOP_DHIGH
    } t_phase;

    logic [7:0]  r_store [DIGIT_COUNT];
    logic [3:0]  r_brightness;
    logic        r_bright_en;
    logic [15:0] r_half_bit;

    t_phase      r_phase,    n_phase;
    logic [15:0] r_tick,     n_tick;
    logic [1:0]  r_halves,   n_halves;
    logic [3:0]  r_bit_cnt,  n_bit_cnt;
    logic [2:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]  r_shift,    n_shift;
    logic [1:0]  r_frame,    n_frame;
    logic [2:0]  r_len,      n_len;
    logic [1:0]  r_pos,      n_pos;
    logic        r_clk_lvl,  n_clk_lvl;
    logic        r_dat_lvl,  n_dat_lvl;
    logic        r_valid;
    logic        r_clock_pin;
    logic        r_data_pin;
    logic        r_busy;

    logic        pop;
    logic        busy;
    logic        do_load;
    logic [15:0] half_len;
    logic [15:0] tick_dec;
    logic [3:0]  bit_inc;

    assign busy     = (r_phase != PH_IDLE);
    assign pop      = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop  = pop;
    assign do_load  = pop && (i_q_item.kind == CMD_LOAD) && !busy;
    assign half_len = (r_half_bit == 16'd0) ? 16'd1 : r_half_bit;
    assign tick_dec = r_tick - {15'd0, (r_tick != 16'd0)};
    assign bit_inc  = r_bit_cnt + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_halves   = r_halves;
        n_bit_cnt  = r_bit_cnt;
        n_byte_cnt = r_byte_cnt;
        n_shift    = r_shift;
        n_frame    = r_frame;
        n_len      = r_len;
        n_pos      = r_pos;
        n_clk_lvl  = r_clk_lvl;
        n_dat_lvl  = r_dat_lvl;

        if (pop && (i_q_item.kind == CMD_START) && !busy) begin
            n_len      = i_q_item.update_length;
            n_pos      = i_q_item.start_position;
            n_frame    = 2'd0;
            n_shift    = CMD_DATA_WRITE;
            n_bit_cnt  = 4'd0;
            n_byte_cnt = 3'd0;
            n_dat_lvl  = 1'b0;
            n_phase    = PH_START;
            n_tick     = half_len;
            n_halves   = 2'd2;
        end else if (pop && (i_q_item.kind == CMD_TICK) && busy) begin
            if (tick_dec != 16'd0) begin
                n_tick = tick_dec;
            end else if (r_halves > 2'd1) begin
                n_halves = r_halves - 2'd1;
                n_tick   = half_len;
            end else begin
                // wait over: take the next pin step and start its wait
                n_tick = half_len;
                unique case (r_phase)
                    PH_START: begin
                        n_bit_cnt = 4'd0;
                        n_clk_lvl = 1'b0;
                        n_phase   = PH_BIT_LOW;
                        n_halves  = 2'd1;
                    end
                    PH_BIT_LOW: begin
                        n_dat_lvl = r_shift[0];
                        n_phase   = PH_BIT_DATA;
                        n_halves  = 2'd1;
                    end
                    PH_BIT_DATA: begin
                        n_clk_lvl = 1'b1;
                        n_phase   = PH_BIT_HIGH;
                        n_halves  = 2'd2;
                    end
                    PH_BIT_HIGH: begin
                        n_shift   = {1'b0, r_shift[7:1]};
                        n_bit_cnt = bit_inc;
                        n_clk_lvl = 1'b0;
                        if (bit_inc < 4'd8) begin
                            n_phase  = PH_BIT_LOW;
                            n_halves = 2'd1;
                        end else begin
                            n_dat_lvl = 1'b1;
                            n_phase   = PH_ACK_LOW;
                            n_halves  = 2'd2;
                        end
                    end
                    PH_ACK_LOW: begin
                        n_clk_lvl = 1'b1;
                        n_phase   = PH_ACK_HIGH;
                        n_halves  = 2'd2;
                    end
                    PH_ACK_HIGH: begin
                        n_clk_lvl = 1'b0;
                        if ((r_frame == 2'd1) && (r_byte_cnt < r_len)) begin
                            n_shift    = r_store[r_byte_cnt[IDX_W-1:0]];
                            n_byte_cnt = r_byte_cnt + 3'd1;
                            n_bit_cnt  = 4'd0;
                            n_phase    = PH_BIT_LOW;
                            n_halves   = 2'd1;
                        end else begin
                            n_phase  = PH_STOP_LOW;
                            n_halves = 2'd1;
                        end
                    end
                    PH_STOP_LOW: begin
                        n_dat_lvl = 1'b0;
                        n_phase   = PH_STOP_DLOW;
                        n_halves  = 2'd1;
                    end
                    PH_STOP_DLOW: begin
                        n_clk_lvl = 1'b1;
                        n_phase   = PH_STOP_HIGH;
                        n_halves  = 2'd2;
                    end
                    PH_STOP_HIGH: begin
                        n_dat_lvl = 1'b1;
                        n_phase   = PH_STOP_DHIGH;
                        n_halves  = 2'd2;
                    end
                    PH_STOP_DHIGH: begin
                        if (r_frame == 2'd0 || (r_frame == 2'd1 && r_bright_en)) begin
                            n_frame    = r_frame + 2'd1;
                            n_shift    = (r_frame == 2'd0) ? (CMD_ADDRESS | {6'd0, r_pos})
                                                           : (CMD_DISPLAY | {4'd0, r_brightness});
                            n_bit_cnt  = 4'd0;
                            n_byte_cnt = 3'd0;
                            n_dat_lvl  = 1'b0;
                            n_phase    = PH_START;
                            n_halves   = 2'd2;
                        end else begin
                            n_phase  = PH_IDLE;
                            n_tick   = 16'd0;
                            n_halves = 2'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHTNESS_RST;
            r_bright_en  <= 1'b1;
            r_half_bit   <= HALF_BIT_RST;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_store[i] <= 8'd0;
            end
            r_phase      <= PH_IDLE;
            r_tick       <= 16'd0;
            r_halves     <= 2'd0;
            r_bit_cnt    <= 4'd0;
            r_byte_cnt   <= 3'd0;
            r_shift      <= 8'd0;
            r_frame      <= 2'd0;
            r_len        <= 3'd0;
            r_pos        <= 2'd0;
            r_clk_lvl    <= 1'b1;
            r_dat_lvl    <= 1'b1;
            r_valid      <= 1'b0;
            r_clock_pin  <= 1'b1;
            r_data_pin   <= 1'b1;
            r_busy       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_BRIGHTNESS: r_brightness <= i_cfg_data[3:0];
                    REG_BRIGHT_EN:  r_bright_en  <= i_cfg_data[0];
                    REG_HALF_BIT:   r_half_bit   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (do_load) begin
                r_store[i_q_item.digit_index[IDX_W-1:0]] <= i_q_item.segment_byte;
            end
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_halves   <= n_halves;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_shift    <= n_shift;
            r_frame    <= n_frame;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_clk_lvl  <= n_clk_lvl;
            r_dat_lvl  <= n_dat_lvl;
            // result register: one result per popped item
            if (pop) begin
                r_valid     <= 1'b1;
                r_clock_pin <= n_clk_lvl;
                r_data_pin  <= n_dat_lvl;
                r_busy      <= (n_phase != PH_IDLE);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_clock_pin = r_clock_pin;
    assign o_data_pin  = r_data_pin;
    assign o_busy      = r_busy;

`ifndef SYNTHESIS
    a_wait_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_tick != 16'd0) && (r_halves != 2'd0) && (r_halves <= 2'd2))
        else $error("running sequence without a pending wait");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'd8)
        else $error("bit counter past one byte");
    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_cnt <= r_len) && (r_len <= 3'(DIGIT_COUNT)))
        else $error("byte counter beyond latched length");
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !o_q_pop)
        else $error("item taken while result is stalled");
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> r_clk_lvl && r_dat_lvl)
        else $error("pins not released while idle");
`endif

endmodule

### src/two_wire_led_driver_writer.sv
// Top level of the two-wire seven-segment LED driver writer.
//
// Input channel (s_axis): one item per handshake; tuser carries the operation
// (tick, load digit, start update), tdata carries the operands.
// Output channel (m_axis): exactly one result per input item, in order, with
// the clock pin, data pin and busy level as they stand after that item.
// Configuration: write i_cfg_data to register i_cfg_addr while i_cfg_we is
// high (0 brightness, 1 brightness enable, 2 half-bit length in ticks).
// Path: an accepted item waits in the front queue, and its result is then held in
// the sequencer's result register.
// Throughput: one item per cycle while m_axis_tready stays high; the
// sequencer handles every item kind without stalling.
// Pin timing counts tick items only, so the frame length on the wire is set
// by half_bit_ticks and by how often the source sends ticks.
// Reset (synchronous, active low) clears the digit store, loads the register
// defaults, idles the sequencer with both pins high and empties the queue.
// When the receiver stalls the result register holds, the two-entry queue
// fills and s_axis_tready drops until results drain.
module two_wire_led_driver_writer
    import twled_pkg::*;
#(
    parameter int DIGIT_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] digit_index, [10:3] segment_byte, [13:11] update_length,
    // [15:14] start_position
    input  logic [15:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] clock_pin, [1] data_pin, [2] busy_res, [7:3] zero
    output logic [7:0]  m_axis_tdata
);

    logic      q_valid;
    t_cmd_item q_item;
    logic      q_pop;
    logic      clock_pin;
    logic      data_pin;
    logic      busy;

    twled_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_operation      (s_axis_tuser),
        .i_digit_index    (s_axis_tdata[2:0]),
        .i_segment_byte   (s_axis_tdata[10:3]),
        .i_update_length  (s_axis_tdata[13:11]),
        .i_start_position (s_axis_tdata[15:14]),
        .o_q_valid        (q_valid),
        .o_q_item         (q_item),
        .i_q_pop          (q_pop)
    );

    twled_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_clock_pin (clock_pin),
        .o_data_pin  (data_pin),
        .o_busy      (busy)
    );

    assign m_axis_tdata = {5'd0, busy, data_pin, clock_pin};

endmodule

### sim/tb_two_wire_led_driver_writer.sv
// Self-checking testbench for the two-wire LED driver writer: pin levels per item.
module tb_two_wire_led_driver_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import twled_pkg::*;

    localparam int         DIGIT_COUNT = 6;
    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         LONG_HOLD   = 400;
    localparam int         CYCLE_LIMIT = 1_000_000;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START, SEQ_BIT_LOW, SEQ_BIT_DATA, SEQ_BIT_HIGH, SEQ_ACK_LOW,
        SEQ_ACK_HIGH, SEQ_STOP_LOW, SEQ_STOP_DLOW, SEQ_STOP_HIGH, SEQ_STOP_DHIGH
    } t_seq_phase;

    // bit 0 clock pin, bit 1 data pin, bit 2 busy
    typedef struct packed {
        logic busy;
        logic dat;
        logic clk;
    } t_pins;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] idx;
        logic [7:0] seg;
        logic [2:0] len;
        logic [1:0] pos;
        logic       typed;
        t_pins      want;
    } t_stim_row;

    localparam t_pins PINS_IDLE  = '{busy: 1'b0, dat: 1'b1, clk: 1'b1};
    localparam t_pins PINS_START = '{busy: 1'b1, dat: 1'b0, clk: 1'b1};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    two_wire_led_driver_writer #(.DIGIT_COUNT(DIGIT_COUNT)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Line sequencer copy
    logic [3:0]  cfg_bright;
    logic        cfg_bright_en;
    logic [15:0] cfg_half_bit;
    logic [7:0]  digit_mem [0:DIGIT_COUNT-1];
    t_seq_phase  wire_phase;
    logic [15:0] wire_ticks;
    logic [1:0]  wire_halves;
    logic [3:0]  wire_bits;
    logic [2:0]  wire_bytes;
    logic [7:0]  wire_shift;
    logic [1:0]  wire_frame;
    logic [2:0]  upd_len;
    logic [1:0]  upd_pos;
    logic        wire_clk;
    logic        wire_dat;

    t_pins     pin_q [$];
    t_stim_row dir_rows [$];

    int src_idle_pct;
    int snk_stall_pct;
    bit long_hold_req;
    int fail_count;
    int items_sent;
    int results_seen;
    int updates_run;
    int cycle_cnt;

    function automatic void arm_wait(input t_seq_phase ph, input logic [1:0] halves);
        wire_phase  = ph;
        wire_ticks  = (cfg_half_bit == 16'd0) ? 16'd1 : cfg_half_bit;
        wire_halves = halves;
    endfunction

    function automatic void open_frame(input logic [1:0] frame, input logic [7:0] first);
        wire_frame = frame;
        wire_shift = first;
        wire_bits  = 4'd0;
        wire_bytes = 3'd0;
        wire_dat   = 1'b0;
        arm_wait(SEQ_START, 2'd2);
    endfunction

    function automatic void advance_wire();
        case (wire_phase)
            SEQ_START: begin
                wire_bits = 4'd0;
                wire_clk  = 1'b0;
                arm_wait(SEQ_BIT_LOW, 2'd1);
            end
            SEQ_BIT_LOW: begin
                wire_dat = wire_shift[0];
                arm_wait(SEQ_BIT_DATA, 2'd1);
            end
            SEQ_BIT_DATA: begin
                wire_clk = 1'b1;
                arm_wait(SEQ_BIT_HIGH, 2'd2);
            end
            SEQ_BIT_HIGH: begin
                wire_shift = wire_shift >> 1;
                wire_bits  = wire_bits + 4'd1;
                wire_clk   = 1'b0;
                if (wire_bits < 4'd8) begin
                    arm_wait(SEQ_BIT_LOW, 2'd1);
                end else begin
                    wire_dat = 1'b1;
                    arm_wait(SEQ_ACK_LOW, 2'd2);
                end
            end
            SEQ_ACK_LOW: begin
                wire_clk = 1'b1;
                arm_wait(SEQ_ACK_HIGH, 2'd2);
            end
            SEQ_ACK_HIGH: begin
                wire_clk = 1'b0;
                // address frame carries the digit bytes after its command
                if (wire_frame == 2'd1 && wire_bytes < upd_len) begin
                    wire_shift = digit_mem[wire_bytes];
                    wire_bytes = wire_bytes + 3'd1;
                    wire_bits  = 4'd0;
                    arm_wait(SEQ_BIT_LOW, 2'd1);
                end else begin
                    arm_wait(SEQ_STOP_LOW, 2'd1);
                end
            end
            SEQ_STOP_LOW: begin
                wire_dat = 1'b0;
                arm_wait(SEQ_STOP_DLOW, 2'd1);
            end
            SEQ_STOP_DLOW: begin
                wire_clk = 1'b1;
                arm_wait(SEQ_STOP_HIGH, 2'd2);
            end
            SEQ_STOP_HIGH: begin
                wire_dat = 1'b1;
                arm_wait(SEQ_STOP_DHIGH, 2'd2);
            end
            SEQ_STOP_DHIGH: begin
                if (wire_frame == 2'd0) begin
                    open_frame(2'd1, CMD_ADDRESS + {6'd0, upd_pos});
                end else if (wire_frame == 2'd1 && cfg_bright_en) begin
                    open_frame(2'd2, CMD_DISPLAY + {4'd0, cfg_bright});
                end else begin
                    wire_phase  = SEQ_IDLE;
                    wire_ticks  = 16'd0;
                    wire_halves = 2'd0;
                end
            end
            default: wire_phase = SEQ_IDLE;
        endcase
    endfunction

    function automatic void wire_tick();
        if (wire_phase == SEQ_IDLE) return;
        if (wire_ticks != 16'd0) wire_ticks = wire_ticks - 16'd1;
        if (wire_ticks != 16'd0) return;
        if (wire_halves > 2'd1) begin
            wire_halves = wire_halves - 2'd1;
            wire_ticks  = (cfg_half_bit == 16'd0) ? 16'd1 : cfg_half_bit;
            return;
        end
        advance_wire();
    endfunction

    function automatic t_pins predict_pins(input logic [1:0] op, input logic [15:0] data);
        t_pins p;
        logic  idle;
        idle = (wire_phase == SEQ_IDLE);
        case (op)
            OP_TICK: wire_tick();
            OP_LOAD: begin
                if (idle && int'(data[2:0]) < DIGIT_COUNT) digit_mem[data[2:0]] = data[10:3];
            end
            OP_START: begin
                if (idle) begin
                    upd_len = (int'(data[13:11]) > DIGIT_COUNT) ? 3'(DIGIT_COUNT)
                                                                 : data[13:11];
                    upd_pos = data[15:14];
                    updates_run++;
                    open_frame(2'd0, CMD_DATA_WRITE);
                end
            end
            default: ;
        endcase
        p.clk  = wire_clk;
        p.dat  = wire_dat;
        p.busy = (wire_phase != SEQ_IDLE);
        return p;
    endfunction

    // Called and returns on a falling edge; valid stays up after the item is taken.
    task automatic send_item(input logic [1:0] op, input logic [15:0] data,
                             input logic typed, input t_pins want);
        t_pins p;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_pins(op, data);
        pin_q.push_back(typed ? want : p);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [3:0] bright, input logic en, input logic [15:0] half);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_BRIGHTNESS;
        i_cfg_data <= {12'd0, bright};
        @(negedge i_clk);
        cfg_bright = bright;
        i_cfg_addr <= REG_BRIGHT_EN;
        i_cfg_data <= {15'd0, en};
        @(negedge i_clk);
        cfg_bright_en = en;
        i_cfg_addr <= REG_HALF_BIT;
        i_cfg_data <= half;
        @(negedge i_clk);
        cfg_half_bit = half;
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pin_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly ticks while an update runs, with ignored loads/starts mixed in as noise.
    task automatic send_random(input int n);
        logic [1:0]  op;
        logic [15:0] data;
        int          r;
        for (int i = 0; i < n; i++) begin
            data = 16'($urandom);
            r    = $urandom_range(99);
            if (wire_phase != SEQ_IDLE)
                op = (r < 86) ? OP_TICK : 2'($urandom_range(3));
            else if (r < 35)
                op = OP_LOAD;
            else if (r < 55)
                op = OP_START;
            else if (r < 92)
                op = OP_TICK;
            else
                op = OP_NONE;
            send_item(op, data, 1'b0, PINS_IDLE);
        end
    endtask

    task automatic tick_until_idle();
        while (wire_phase != SEQ_IDLE) send_item(OP_TICK, 16'($urandom), 1'b0, PINS_IDLE);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                         pin_q.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pins got;
        t_pins want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_pins'(m_axis_tdata[2:0]);
            results_seen++;
            if (pin_q.size() == 0) begin
                $error("result 0x%02h arrived with nothing expected", m_axis_tdata);
                fail_count++;
            end else begin
                want = pin_q.pop_front();
                if (got.clk !== want.clk) begin
                    $error("clock_pin: expected %0d, actual %0d", want.clk, got.clk);
                    fail_count++;
                end
                if (got.dat !== want.dat) begin
                    $error("data_pin: expected %0d, actual %0d", want.dat, got.dat);
                    fail_count++;
                end
                if (got.busy !== want.busy) begin
                    $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = 2'd0;
        i_cfg_data    = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = OP_TICK;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        long_hold_req = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        results_seen  = 0;
        updates_run   = 0;

        cfg_bright    = BRIGHTNESS_RST;
        cfg_bright_en = 1'b1;
        cfg_half_bit  = HALF_BIT_RST;
        for (int i = 0; i < DIGIT_COUNT; i++) digit_mem[i] = 8'h00;
        wire_phase  = SEQ_IDLE;
        wire_ticks  = 16'd0;
        wire_halves = 2'd0;
        wire_bits   = 4'd0;
        wire_bytes  = 3'd0;
        wire_shift  = 8'h00;
        wire_frame  = 2'd0;
        upd_len     = 3'd0;
        upd_pos     = 2'd0;
        wire_clk    = 1'b1;
        wire_dat    = 1'b1;

        // op, index, segments, length, position, typed, expected pins
        dir_rows.push_back('{OP_TICK,  3'd0, 8'h00, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_NONE,  3'd7, 8'hFF, 3'd7, 2'd3, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd0, 8'hFF, 3'd7, 2'd3, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd5, 8'h00, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd1, 8'h01, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd2, 8'h80, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd3, 8'h55, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd4, 8'hAA, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        // out-of-range digit slots are dropped
        dir_rows.push_back('{OP_LOAD,  3'd6, 8'h5A, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        dir_rows.push_back('{OP_LOAD,  3'd7, 8'hA5, 3'd0, 2'd0, 1'b1, PINS_IDLE});
        // length 7 clips to six digits
        dir_rows.push_back('{OP_START, 3'd0, 8'h00, 3'd7, 2'd3, 1'b1, PINS_START});
        // busy: loads, starts and unused ops do nothing
        dir_rows.push_back('{OP_LOAD,  3'd0, 8'h00, 3'd0, 2'd0, 1'b1, PINS_START});
        dir_rows.push_back('{OP_START, 3'd0, 8'h00, 3'd0, 2'd0, 1'b1, PINS_START});
        dir_rows.push_back('{OP_NONE,  3'd0, 8'h00, 3'd0, 2'd0, 1'b1, PINS_START});
        dir_rows.push_back('{OP_TICK,  3'd0, 8'h00, 3'd0, 2'd0, 1'b1, PINS_START});
        dir_rows.push_back('{OP_TICK,  3'd0, 8'h00, 3'd0, 2'd0, 1'b0, PINS_IDLE});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op,
                      {dir_rows[i].pos, dir_rows[i].len, dir_rows[i].seg, dir_rows[i].idx},
                      dir_rows[i].typed, dir_rows[i].want);
        wait_results();

        // zero half-bit length, written while the update is still on the wire
        set_regs(4'd15, 1'b1, 16'd0);
        long_hold_req = 1'b1;
        send_random(400);
        wait_results();

        set_regs(4'd0, 1'b0, 16'd1);
        src_idle_pct = 57;
        send_random(400);
        wait_results();

        set_regs(4'($urandom_range(15)), 1'b1, 16'd2);
        src_idle_pct  = 0;
        snk_stall_pct = 57;
        send_random(200);
        wait_results();
        send_random(200);
        wait_results();

        set_regs(4'($urandom_range(15)), 1'($urandom_range(1)), 16'd1);
        src_idle_pct  = 38;
        snk_stall_pct = 38;
        send_random(400);
        wait_results();

        // longest half-bit: the start wait loads 65535 ticks and is left running
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        tick_until_idle();
        wait_results();
        set_regs(4'd15, 1'b1, 16'hFFFF);
        send_item(OP_START, {2'd0, 3'd6, 8'h00, 3'd0}, 1'b0, PINS_IDLE);
        repeat (16) send_item(OP_TICK, 16'($urandom), 1'b0, PINS_IDLE);
        wait_results();

        $display("%0d items sent, %0d results checked, %0d display updates started",
                 items_sent, results_seen, updates_run);
        $display("half-bit lengths 0, 1, 2, 65535; brightness 0..15, control frame on and off");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
